[rtl/core/rx_l4_checksum_verifier_macros.svh]
// Assertion macros for the checksum verifier RTL
`ifndef RX_L4_CHECKSUM_VERIFIER_MACROS_SVH
`define RX_L4_CHECKSUM_VERIFIER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define RLCV_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlcv: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define RLCV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlcv: next-cycle check failed");

`endif

[rtl/core/rlcv_pkg.sv]
// Types, constants and helpers for the L4 checksum verifier
`default_nettype none

package rlcv_pkg;

  localparam logic [7:0] V4_FIRST_BYTE = 8'h45;
  localparam int unsigned V4_HDR_WORDS = 5;
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [5:0] MAX_BYTES     = 6'd48;
  localparam logic [5:0] V4_HDR_BYTES  = 6'(V4_HDR_WORDS * 4);
  localparam logic [5:0] V6_HDR_BYTES  = 6'd40;
  localparam logic [5:0] V4_ADDR_FIRST = 6'd12;
  localparam logic [5:0] V6_ADDR_FIRST = 6'd8;
  localparam logic [5:0] V4_LEN_POS    = 6'd2;
  localparam logic [5:0] V4_FRAG_POS   = 6'd6;
  localparam logic [5:0] V4_UDP_POS    = 6'd26;
  localparam logic [5:0] V6_LEN_POS    = 6'd4;
  localparam logic [5:0] V6_UDP_POS    = 6'd46;

  localparam logic [15:0] V4_HDR_LEN  = 16'(V4_HDR_WORDS * 4);
  localparam logic [15:0] V6_HDR_LEN  = 16'd40;
  localparam logic [15:0] TCP_HDR_LEN = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  localparam logic [13:0] FRAG_MASK_ZERO = 14'd0;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    VERDICT_OK            = 3'd0,
    VERDICT_NOT_SUPPORTED = 3'd1,
    VERDICT_HDR_ERR       = 3'd2,
    VERDICT_CSUM_ERR      = 3'd3,
    VERDICT_UDP_UNCHECKED = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [15:0] header_sum;
    logic [15:0] address_sum;
    logic [7:0]  version_byte;
    logic [15:0] fragment_word;
    logic [15:0] declared_length;
    logic [15:0] udp_check_word;
    logic [15:0] frame_length;
    logic [15:0] engine_sum;
    logic [7:0]  l4_protocol;
    logic        ip_typed;
    logic        engine_csum_valid;
    logic        is_v4;
  } frame_sum_t;

  function automatic logic [15:0] add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

`default_nettype wire

[rtl/core/rlcv_if.sv]
// Byte input and result channel interfaces
`default_nettype none

interface rlcv_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        last_byte;
  logic [15:0] frame_length;
  logic [15:0] engine_sum;
  logic [7:0]  l4_protocol;
  logic        ip_typed;
  logic        engine_csum_valid;
  logic        is_v4;

  modport source (
    output valid, frame_byte, last_byte, frame_length, engine_sum, l4_protocol,
           ip_typed, engine_csum_valid, is_v4,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, last_byte, frame_length, engine_sum, l4_protocol,
           ip_typed, engine_csum_valid, is_v4,
    output ready
  );
endinterface

interface rlcv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [15:0] effective_length;

  modport source (output valid, verdict, effective_length, input ready);
  modport sink (input valid, verdict, effective_length, output ready);
endinterface

`default_nettype wire

[rtl/core/rlcv_front.sv]
// Front end: per-byte header capture and running sums
`default_nettype none

module rlcv_front import rlcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlcv_in_if.sink    data_i,
  input  logic       q_full_i,
  output logic       push_o,
  output frame_sum_t rec_o
);

  logic [5:0]  idx_q, idx_d;
  logic [15:0] hsum_q, hsum_d;
  logic [15:0] asum_q, asum_d;
  logic [7:0]  odd_q, odd_d;
  logic [7:0]  ver_q, ver_d;
  logic [15:0] frag_q, frag_d;
  logic [15:0] dlen_q, dlen_d;
  logic [15:0] udp_q, udp_d;
  logic        beat;

  assign data_i.ready = !q_full_i;
  assign beat         = data_i.valid && data_i.ready;
  assign push_o       = beat && data_i.last_byte;

  always_comb begin
    logic [15:0] part;
    logic [15:0] word;
    logic [5:0]  pos;
    logic        in_hdr;
    logic        in_addr;
    idx_d  = idx_q;
    hsum_d = hsum_q;
    asum_d = asum_q;
    odd_d  = odd_q;
    ver_d  = ver_q;
    frag_d = frag_q;
    dlen_d = dlen_q;
    udp_d  = udp_q;
    part   = idx_q[0] ? {8'h00, data_i.frame_byte} : {data_i.frame_byte, 8'h00};
    word   = idx_q[0] ? {odd_q, data_i.frame_byte} : {data_i.frame_byte, 8'h00};
    pos    = {idx_q[5:1], 1'b0};
    if (data_i.is_v4) begin
      in_hdr  = idx_q < V4_HDR_BYTES;
      in_addr = idx_q inside {[V4_ADDR_FIRST : V4_HDR_BYTES - 6'd1]};
    end else begin
      in_hdr  = idx_q < V6_HDR_BYTES;
      in_addr = idx_q inside {[V6_ADDR_FIRST : V6_HDR_BYTES - 6'd1]};
    end
    if (idx_q < MAX_BYTES) begin
      if (in_hdr) begin
        hsum_d = add16(hsum_q, part);
      end
      if (in_addr) begin
        asum_d = add16(asum_q, part);
      end
      if (!idx_q[0]) begin
        odd_d = data_i.frame_byte;
      end
      if (idx_q == 6'd0) begin
        ver_d = data_i.frame_byte;
      end
      if (data_i.is_v4) begin
        if (pos == V4_LEN_POS)  dlen_d = word;
        if (pos == V4_FRAG_POS) frag_d = word;
        if (pos == V4_UDP_POS)  udp_d  = word;
      end else begin
        if (pos == V6_LEN_POS)  dlen_d = word;
        if (pos == V6_UDP_POS)  udp_d  = word;
      end
      idx_d = idx_q + 6'd1;
    end
  end

  always_comb begin
    rec_o.header_sum        = hsum_d;
    rec_o.address_sum       = asum_d;
    rec_o.version_byte      = ver_d;
    rec_o.fragment_word     = frag_d;
    rec_o.declared_length   = dlen_d;
    rec_o.udp_check_word    = udp_d;
    rec_o.frame_length      = data_i.frame_length;
    rec_o.engine_sum        = data_i.engine_sum;
    rec_o.l4_protocol       = data_i.l4_protocol;
    rec_o.ip_typed          = data_i.ip_typed;
    rec_o.engine_csum_valid = data_i.engine_csum_valid;
    rec_o.is_v4             = data_i.is_v4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      hsum_q <= '0;
      asum_q <= '0;
      odd_q  <= '0;
      ver_q  <= '0;
      frag_q <= '0;
      dlen_q <= '0;
      udp_q  <= '0;
    end else if (beat) begin
      if (data_i.last_byte) begin
        idx_q  <= '0;
        hsum_q <= '0;
        asum_q <= '0;
        odd_q  <= '0;
        ver_q  <= '0;
        frag_q <= '0;
        dlen_q <= '0;
        udp_q  <= '0;
      end else begin
        idx_q  <= idx_d;
        hsum_q <= hsum_d;
        asum_q <= asum_d;
        odd_q  <= odd_d;
        ver_q  <= ver_d;
        frag_q <= frag_d;
        dlen_q <= dlen_d;
        udp_q  <= udp_d;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/rlcv_fifo.sv]
// Short queue of per-frame summaries between front and back
`default_nettype none

module rlcv_fifo import rlcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frame_sum_t rec_i,
  output logic       full_o,
  output logic       valid_o,
  input  logic       pop_i,
  output frame_sum_t rec_o
);

  localparam logic [QUEUE_CNT_W-1:0] DEPTH = QUEUE_CNT_W'(QUEUE_DEPTH);

  frame_sum_t                 mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0]     count_q;

  assign full_o  = count_q == DEPTH;
  assign valid_o = count_q != '0;
  assign rec_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
      if (push_i && !pop_i) begin
        count_q <= count_q + QUEUE_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QUEUE_CNT_W'(1);
      end
    end
  end

  `include "rx_l4_checksum_verifier_macros.svh"

  `RLCV_ASSERT_IMPL(a_pop_not_empty, pop_i, count_q != '0)
  `RLCV_ASSERT_IMPL(a_push_not_full, push_i, count_q != DEPTH)
  `RLCV_ASSERT_NEXT(a_count_up, push_i && !pop_i, count_q == $past(count_q) + QUEUE_CNT_W'(1))

endmodule

`default_nettype wire

[rtl/core/rlcv_back.sv]
// Back end: header checks, checksum fold and result register
`default_nettype none

module rlcv_back import rlcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  frame_sum_t rec_i,
  output logic       pop_o,
  rlcv_out_if.source result_o
);

  typedef struct packed {
    verdict_e    verdict;
    logic        check;
    logic [15:0] eff;
    logic [15:0] p1;
    logic [15:0] acc1;
    logic [7:0]  proto;
  } back_stage_t;

  back_stage_t s1_q, s1_d;
  logic        s1_vq;
  logic        out_vq;
  verdict_e    verdict_q;
  logic [15:0] eff_q;
  logic        out_free;
  logic        s1_free;

  assign out_free = !out_vq || result_o.ready;
  assign s1_free  = !s1_vq || out_free;
  assign pop_o    = valid_i && s1_free;

  always_comb begin
    logic        supported;
    logic        ok4;
    logic        ok6;
    logic        ok;
    logic [15:0] l4;
    logic [16:0] full;
    logic [15:0] plen;
    supported = rec_i.ip_typed && rec_i.engine_csum_valid &&
                (rec_i.l4_protocol == PROTO_TCP || rec_i.l4_protocol == PROTO_UDP);
    ok4 = rec_i.frame_length >= V4_HDR_LEN && rec_i.version_byte == V4_FIRST_BYTE &&
          rec_i.fragment_word[13:0] == FRAG_MASK_ZERO && rec_i.header_sum == 16'hFFFF &&
          rec_i.frame_length >= rec_i.declared_length &&
          rec_i.declared_length >= V4_HDR_LEN;
    l4   = (rec_i.l4_protocol == PROTO_TCP) ? TCP_HDR_LEN : UDP_HDR_LEN;
    full = {1'b0, rec_i.declared_length} + {1'b0, V6_HDR_LEN};
    ok6  = rec_i.frame_length >= V6_HDR_LEN + l4 && rec_i.declared_length >= l4 &&
           {1'b0, rec_i.frame_length} >= full;
    ok   = rec_i.is_v4 ? ok4 : ok6;
    plen = rec_i.is_v4 ? rec_i.declared_length - V4_HDR_LEN : rec_i.declared_length;

    s1_d.check = 1'b0;
    s1_d.eff   = rec_i.frame_length;
    s1_d.p1    = add16(rec_i.address_sum, plen);
    s1_d.acc1  = add16(~rec_i.engine_sum, rec_i.header_sum);
    s1_d.proto = rec_i.l4_protocol;
    if (!supported) begin
      s1_d.verdict = VERDICT_NOT_SUPPORTED;
    end else if (!ok) begin
      s1_d.verdict = VERDICT_HDR_ERR;
    end else begin
      s1_d.eff = rec_i.is_v4 ? rec_i.declared_length : full[15:0];
      if (rec_i.l4_protocol == PROTO_UDP && rec_i.udp_check_word == 16'd0) begin
        s1_d.verdict = VERDICT_UDP_UNCHECKED;
      end else begin
        s1_d.verdict = VERDICT_OK;
        s1_d.check   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq  <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      if (s1_free) s1_vq  <= valid_i;
      if (out_free) out_vq <= s1_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [15:0] pseudo;
    logic [15:0] acc;
    pseudo = add16(s1_q.p1, {8'h00, s1_q.proto});
    acc    = add16(s1_q.acc1, ~pseudo);
    if (out_free && s1_vq) begin
      eff_q <= s1_q.eff;
      if (s1_q.check) begin
        verdict_q <= (acc == 16'hFFFF) ? VERDICT_OK : VERDICT_CSUM_ERR;
      end else begin
        verdict_q <= s1_q.verdict;
      end
    end
  end

  assign result_o.valid            = out_vq;
  assign result_o.verdict          = verdict_q;
  assign result_o.effective_length = eff_q;

endmodule

`default_nettype wire

[rtl/core/rx_l4_checksum_verifier.sv]
// Receive-side TCP/UDP checksum verifier, top level.
// Header bytes enter one beat per cycle while the queue is not full, starting
// at the IP header; each frame's last beat carries the frame metadata and yields
// one result (verdict and trimmed length). The front captures header words and
// keeps the running ones' complement sums, so a beat never waits on the
// arithmetic; a two-entry summary queue feeds a two-stage back end that does
// the header checks and the end-around checksum fold. A frame's summary
// passes through the queue, the stage-one register and the result register.
// The input stalls only when the queue is full, i.e. when the result side
// holds ready low long enough to back up two further frames.
`default_nettype none

module rx_l4_checksum_verifier import rlcv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rlcv_in_if.sink    data_i,
  rlcv_out_if.source result_o
);

  logic       push;
  logic       full;
  logic       q_valid;
  logic       pop;
  frame_sum_t rec_in;
  frame_sum_t rec_head;

  rlcv_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .data_i   (data_i),
    .q_full_i (full),
    .push_o   (push),
    .rec_o    (rec_in)
  );

  rlcv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .rec_o   (rec_head)
  );

  rlcv_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .rec_i    (rec_head),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

`default_nettype wire

[dv/rlcv_checker.sv]
// Checker for the L4 checksum verifier: predicts each frame's verdict and compares results
module rlcv_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rlcv_in_if   beat_i,
  rlcv_out_if  result_i,
  output int   fail_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import rlcv_pkg::*;

  localparam logic [5:0]  SPAN_BYTES   = 6'd48;
  localparam logic [5:0]  V4_HDR_END   = 6'd20;
  localparam logic [5:0]  V6_HDR_END   = 6'd40;
  localparam logic [5:0]  V4_ADDR_LO   = 6'd12;
  localparam logic [5:0]  V6_ADDR_LO   = 6'd8;
  localparam logic [5:0]  V4_TLEN_AT   = 6'd2;
  localparam logic [5:0]  V4_FRAG_AT   = 6'd6;
  localparam logic [5:0]  V4_UCSUM_AT  = 6'd26;
  localparam logic [5:0]  V6_PLEN_AT   = 6'd4;
  localparam logic [5:0]  V6_UCSUM_AT  = 6'd46;
  localparam logic [7:0]  V4_VER_IHL   = 8'h45;
  localparam logic [15:0] V4_MIN_LEN   = 16'd20;
  localparam logic [15:0] V6_FIXED_LEN = 16'd40;
  localparam logic [15:0] TCP_MIN_LEN  = 16'd20;
  localparam logic [15:0] UDP_MIN_LEN  = 16'd8;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] eff_len;
  } verdict_rec_t;

  verdict_rec_t expected_verdicts[$];
  verdict_rec_t head;
  int           mismatches;

  logic [5:0]  beat_idx;
  logic [15:0] hdr_acc;
  logic [15:0] addr_acc;
  logic [7:0]  hold_byte;
  logic [7:0]  first_byte;
  logic [15:0] frag_word;
  logic [15:0] len_word;
  logic [15:0] udp_csum_word;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  task automatic clear_frame();
    beat_idx      = '0;
    hdr_acc       = '0;
    addr_acc      = '0;
    hold_byte     = '0;
    first_byte    = '0;
    frag_word     = '0;
    len_word      = '0;
    udp_csum_word = '0;
  endtask

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic v4);
    logic [15:0] part;
    logic [15:0] word;
    logic [5:0]  pos;
    if (beat_idx >= SPAN_BYTES) return;
    part = beat_idx[0] ? {8'h00, b} : {b, 8'h00};
    if (beat_idx < (v4 ? V4_HDR_END : V6_HDR_END)) hdr_acc = ones_add(hdr_acc, part);
    if (v4 ? (beat_idx >= V4_ADDR_LO && beat_idx < V4_HDR_END)
           : (beat_idx >= V6_ADDR_LO && beat_idx < V6_HDR_END)) begin
      addr_acc = ones_add(addr_acc, part);
    end
    if (beat_idx[0]) begin
      word = {hold_byte, b};
    end else begin
      hold_byte = b;
      word = {b, 8'h00};
    end
    pos = {beat_idx[5:1], 1'b0};
    if (beat_idx == 6'd0) first_byte = b;
    if (v4) begin
      if (pos == V4_TLEN_AT) len_word = word;
      if (pos == V4_FRAG_AT) frag_word = word;
      if (pos == V4_UCSUM_AT) udp_csum_word = word;
    end else begin
      if (pos == V6_PLEN_AT) len_word = word;
      if (pos == V6_UCSUM_AT) udp_csum_word = word;
    end
    beat_idx = beat_idx + 6'd1;
  endtask

  function automatic verdict_rec_t close_frame(input logic [15:0] flen, input logic [15:0] esum,
                                               input logic [7:0] proto, input logic ip_typed,
                                               input logic csum_valid, input logic v4);
    verdict_rec_t r;
    logic         ok;
    logic [15:0]  l4_min;
    logic [16:0]  full;
    logic [15:0]  plen;
    logic [15:0]  pseudo;
    logic [15:0]  acc;
    r.eff_len = flen;
    if (!ip_typed || !csum_valid || (proto != PROTO_TCP && proto != PROTO_UDP)) begin
      r.verdict = VERDICT_NOT_SUPPORTED;
      return r;
    end
    if (v4) begin
      ok = flen >= V4_MIN_LEN && first_byte == V4_VER_IHL && frag_word[13:0] == 14'd0 &&
           hdr_acc == 16'hFFFF && flen >= len_word && len_word >= V4_MIN_LEN;
      plen = len_word - V4_MIN_LEN;
      if (ok) r.eff_len = len_word;
    end else begin
      l4_min = (proto == PROTO_TCP) ? TCP_MIN_LEN : UDP_MIN_LEN;
      full = {1'b0, len_word} + {1'b0, V6_FIXED_LEN};
      ok = {1'b0, flen} >= ({1'b0, V6_FIXED_LEN} + {1'b0, l4_min}) && len_word >= l4_min &&
           {1'b0, flen} >= full;
      plen = len_word;
      if (ok) r.eff_len = full[15:0];
    end
    if (!ok) begin
      r.verdict = VERDICT_HDR_ERR;
      r.eff_len = flen;
    end else if (proto == PROTO_UDP && udp_csum_word == 16'd0) begin
      r.verdict = VERDICT_UDP_UNCHECKED;
    end else begin
      pseudo = ones_add(ones_add(addr_acc, plen), {8'h00, proto});
      acc = ones_add(ones_add(~esum, hdr_acc), ~pseudo);
      r.verdict = (acc == 16'hFFFF) ? VERDICT_OK : VERDICT_CSUM_ERR;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_frame();
      expected_verdicts.delete();
      mismatches = 0;
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result beat with nothing pending, verdict", result_i.verdict, 0);
        end else begin
          head = expected_verdicts.pop_front();
          if (result_i.verdict !== head.verdict)
            flag_mismatch("verdict", result_i.verdict, head.verdict);
          if (result_i.effective_length !== head.eff_len)
            flag_mismatch("effective_length", result_i.effective_length, head.eff_len);
        end
      end
      if (beat_i.valid && beat_i.ready) begin
        absorb_byte(beat_i.frame_byte, beat_i.is_v4);
        if (beat_i.last_byte) begin
          expected_verdicts.push_back(close_frame(beat_i.frame_length, beat_i.engine_sum,
                                                  beat_i.l4_protocol, beat_i.ip_typed,
                                                  beat_i.engine_csum_valid, beat_i.is_v4));
          clear_frame();
        end
      end
      fail_count_o <= mismatches;
      outstanding_o <= expected_verdicts.size();
    end
  end

endmodule

[dv/tb_rx_l4_checksum_verifier.sv]
// Testbench top for the L4 checksum verifier: clock, reset, frame stimulus and verdict
module tb_rx_l4_checksum_verifier;
  timeunit 1ns;
  timeprecision 1ps;
  import rlcv_pkg::*;

  localparam int BEAT_TARGET  = 1650;
  localparam int CALM_AFTER   = 1400;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AT      = 8;
  localparam int DRAIN_AT     = 20;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct packed {
    logic [15:0] flen;
    logic [15:0] esum;
    logic [7:0]  proto;
    logic        ip_typed;
    logic        csum_valid;
    logic        v4;
  } frame_meta_t;

  logic clk_i;
  logic rst_ni;

  rlcv_in_if  beat_if ();
  rlcv_out_if res_if ();

  int fail_count;
  int outstanding;
  int beats_sent;
  int frames_done;
  int idle_cycles;
  bit calm;
  bit hold_done;

  logic [7:0] frame_bytes [0:63];

  rx_l4_checksum_verifier uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .data_i  (beat_if),
    .result_o(res_if)
  );

  rlcv_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat_if),
    .result_i     (res_if),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [15:0] wrap_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic logic [15:0] span_sum(input int lo, input int hi);
    logic [15:0] s;
    s = '0;
    for (int i = lo; i <= hi; i++)
      s = wrap_add(s, (i % 2) ? {8'h00, frame_bytes[i]} : {frame_bytes[i], 8'h00});
    return s;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last, input frame_meta_t m);
    if (!calm && $urandom_range(0, 7) == 0) begin
      beat_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    beat_if.valid             <= 1'b1;
    beat_if.frame_byte        <= b;
    beat_if.last_byte         <= last;
    beat_if.frame_length      <= m.flen;
    beat_if.engine_sum        <= m.esum;
    beat_if.l4_protocol       <= m.proto;
    beat_if.ip_typed          <= m.ip_typed;
    beat_if.engine_csum_valid <= m.csum_valid;
    beat_if.is_v4             <= m.v4;
    @(posedge clk_i);
    while (!beat_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_frame(input int n, input frame_meta_t m, input bit scramble);
    frame_meta_t bm;
    for (int i = 0; i < n; i++) begin
      bm = m;
      if (scramble && i != n - 1) begin
        bm.flen       = 16'($urandom);
        bm.esum       = 16'($urandom);
        bm.proto      = 8'($urandom);
        bm.ip_typed   = 1'($urandom_range(0, 1));
        bm.csum_valid = 1'($urandom_range(0, 1));
        bm.v4         = 1'($urandom_range(0, 1));
      end
      send_beat(frame_bytes[i], i == n - 1, bm);
    end
    frames_done++;
  endtask

  task automatic load_bytes(input logic [47:0] bytes);
    for (int i = 0; i < 64; i++) frame_bytes[i] = (i < 6) ? bytes[47 - 8 * i -: 8] : 8'h00;
  endtask

  task automatic build_frame(output int n, output frame_meta_t m, output bit scramble);
    bit          v4;
    bit          udp;
    int          l4;
    int          dl;
    int          flen;
    int          at;
    logic [15:0] hs;
    logic [15:0] as;
    logic [15:0] plen;
    for (int i = 0; i < 64; i++) frame_bytes[i] = 8'($urandom);
    scramble = 1'b0;
    if ($urandom_range(0, 99) >= 75) begin
      n = $urandom_range(1, 60);
      m.flen       = 16'($urandom);
      m.esum       = 16'($urandom);
      m.proto      = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? PROTO_TCP : PROTO_UDP)
                                          : 8'($urandom);
      m.v4         = 1'($urandom_range(0, 1));
      m.ip_typed   = ($urandom_range(0, 3) != 0);
      m.csum_valid = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) frame_bytes[0] = m.v4 ? 8'h45 : 8'h60;
      scramble = 1'($urandom_range(0, 1));
    end else begin
      v4  = 1'($urandom_range(0, 1));
      udp = 1'($urandom_range(0, 1));
      m.proto = udp ? PROTO_UDP : PROTO_TCP;
      l4 = udp ? 8 : 20;
      if ($urandom_range(0, 15) == 0)
        dl = v4 ? $urandom_range(20 + l4, 65535) : $urandom_range(l4, 65495);
      else
        dl = (v4 ? 20 : 0) + l4 + $urandom_range(0, 200);
      flen = (v4 ? dl : dl + 40) + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 30) : 0);
      m.flen = (flen > 65535) ? 16'hFFFF : 16'(flen);
      if (v4) begin
        frame_bytes[0]  = 8'h45;
        frame_bytes[2]  = 8'(dl >> 8);
        frame_bytes[3]  = 8'(dl);
        frame_bytes[6]  = $urandom_range(0, 1) ? 8'h40 : 8'h00;
        frame_bytes[7]  = 8'h00;
        frame_bytes[9]  = m.proto;
        frame_bytes[10] = 8'h00;
        frame_bytes[11] = 8'h00;
        hs = ~span_sum(0, 19);
        frame_bytes[10] = hs[15:8];
        frame_bytes[11] = hs[7:0];
        at = 26;
      end else begin
        frame_bytes[0] = {4'h6, 4'($urandom)};
        frame_bytes[4] = 8'(dl >> 8);
        frame_bytes[5] = 8'(dl);
        frame_bytes[6] = m.proto;
        at = 46;
      end
      if (udp && $urandom_range(0, 3) == 0) begin
        frame_bytes[at]     = 8'h00;
        frame_bytes[at + 1] = 8'h00;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = 48;
        6, 7, 8:          n = $urandom_range(20, 60);
        default:          n = $urandom_range(1, 19);
      endcase
      for (int i = n; i < 64; i++) frame_bytes[i] = 8'h00;
      hs   = span_sum(0, v4 ? 19 : 39);
      as   = span_sum(v4 ? 12 : 8, v4 ? 19 : 39);
      plen = v4 ? 16'(dl - 20) : 16'(dl);
      m.esum       = wrap_add(hs, ~wrap_add(wrap_add(as, plen), {8'h00, m.proto}));
      m.v4         = v4;
      m.ip_typed   = 1'b1;
      m.csum_valid = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: begin
            at = $urandom_range(0, 47);
            frame_bytes[at] = frame_bytes[at] ^ 8'(1 << $urandom_range(0, 7));
          end
          1: m.esum = m.esum ^ 16'($urandom_range(1, 65535));
          2: begin
            frame_bytes[6] = 8'($urandom);
            frame_bytes[7] = 8'($urandom);
          end
          3: m.flen = 16'($urandom_range(0, m.flen));
          4: m.proto = 8'($urandom);
          default: begin
            m.ip_typed   = 1'($urandom_range(0, 1));
            m.csum_valid = 1'($urandom_range(0, 1));
          end
        endcase
      end
    end
  endtask

  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!hold_done && frames_done >= HOLD_AT) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((beat_if.valid && beat_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int          n;
    frame_meta_t m;
    bit          scramble;
    beat_if.valid             <= 1'b0;
    beat_if.frame_byte        <= '0;
    beat_if.last_byte         <= 1'b0;
    beat_if.frame_length      <= '0;
    beat_if.engine_sum        <= '0;
    beat_if.l4_protocol       <= '0;
    beat_if.ip_typed          <= 1'b0;
    beat_if.engine_csum_valid <= 1'b0;
    beat_if.is_v4             <= 1'b0;
    beats_sent  = 0;
    frames_done = 0;
    calm        = 1'b0;
    hold_done   = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);

    load_bytes(48'h00_0000000000);
    send_frame(1, frame_meta_t'{16'd0, 16'd0, PROTO_TCP, 1'b0, 1'b1, 1'b1}, 1'b0);
    load_bytes(48'hFF_0000000000);
    send_frame(1, frame_meta_t'{16'hFFFF, 16'hFFFF, PROTO_UDP, 1'b1, 1'b0, 1'b0}, 1'b0);
    load_bytes(48'h45_0000000000);
    send_frame(1, frame_meta_t'{16'd20, 16'd0, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0);
    send_frame(1, frame_meta_t'{16'hFFFF, 16'd0, PROTO_TCP, 1'b1, 1'b1, 1'b1}, 1'b0);
    send_frame(1, frame_meta_t'{16'd0, 16'hFFFF, PROTO_UDP, 1'b1, 1'b1, 1'b1}, 1'b0);
    load_bytes(48'h60_0000000000);
    send_frame(1, frame_meta_t'{16'hFFFF, 16'h1234, PROTO_TCP, 1'b1, 1'b1, 1'b0}, 1'b0);
    load_bytes(48'h60_0000000008);
    send_frame(6, frame_meta_t'{16'd48, 16'($urandom), PROTO_UDP, 1'b1, 1'b1, 1'b0}, 1'b0);
    load_bytes(48'h60_0000000014);
    send_frame(6, frame_meta_t'{16'd60, 16'($urandom), PROTO_TCP, 1'b1, 1'b1, 1'b0}, 1'b0);

    while (beats_sent < BEAT_TARGET) begin
      if (beats_sent >= CALM_AFTER) calm = 1'b1;
      if (frames_done == DRAIN_AT) begin
        beat_if.valid <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      build_frame(n, m, scramble);
      send_frame(n, m, scramble);
    end
    beat_if.valid <= 1'b0;

    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rlcv_pkg.sv
rtl/core/rlcv_if.sv
rtl/core/rlcv_front.sv
rtl/core/rlcv_fifo.sv
rtl/core/rlcv_back.sv
rtl/core/rx_l4_checksum_verifier.sv
dv/rlcv_checker.sv
dv/tb_rx_l4_checksum_verifier.sv
